/* src/flstat_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the frame link statistics block.
// No dependencies; imported by the interfaces and the top level.
package flstat_pkg;

    // Width of the wrapping event counters; results show the low 32 bits.
    localparam int COUNT_WIDTH = 32;

    localparam int STAT_WIDTH  = 32;
    localparam int SEQ_WIDTH   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [STAT_WIDTH-1:0]  t_stat;
    typedef logic [SEQ_WIDTH-1:0]   t_seq;

    typedef enum logic [2:0] {
        FUNC_RECV     = 3'd0,
        FUNC_CRC      = 3'd1,
        FUNC_CMD      = 3'd2,
        FUNC_SEQ      = 3'd3,
        FUNC_TOUT_RPT = 3'd4,
        FUNC_SENT     = 3'd5,
        FUNC_TICK     = 3'd6,
        FUNC_INVALID  = 3'd7
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACK_TIMING    = 2'd0,
        CFG_TOUT_REPORT   = 2'd1,
        CFG_TOUT_POLL     = 2'd2,
        CFG_TOUT_TICKS    = 2'd3
    } t_cfg_idx;

    localparam t_stat TOUT_TICKS_RESET = 32'd1000;

endpackage

/* src/flstat_if.sv */
`timescale 1ns / 1ps
// Valid/ready channels of the frame link statistics block: event beats in,
// statistics beats out. Depends on flstat_pkg.
interface flstat_in_if;
    import flstat_pkg::*;

    logic  valid;
    logic  ready;
    t_func func;
    t_seq  value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface flstat_out_if;
    import flstat_pkg::*;

    logic  valid;
    logic  ready;
    logic  status;
    t_stat frames_received;
    t_stat frames_sent;
    t_stat crc_errors;
    t_stat command_errors;
    t_seq  frames_lost;
    t_stat timeouts;
    t_stat latency_total;
    t_stat latency_max;
    t_stat latency_min;

    modport source (
        output valid, output status, output frames_received, output frames_sent,
        output crc_errors, output command_errors, output frames_lost,
        output timeouts, output latency_total, output latency_max,
        output latency_min, input ready
    );
    modport sink (
        input valid, input status, input frames_received, input frames_sent,
        input crc_errors, input command_errors, input frames_lost,
        input timeouts, input latency_total, input latency_max,
        input latency_min, output ready
    );
endinterface

/* src/frame_link_statistics.sv */
`timescale 1ns / 1ps
// Frame link statistics: event counters, sequence gap, round-trip timing.
// Depends on flstat_pkg and the channel interfaces in flstat_if.sv.

// At most one event beat is taken per clock. Its statistics beat appears on
// the output the cycle after acceptance and is held until taken; a new event
// is accepted in the same cycle the pending result is taken, so the sustained
// rate is one beat per cycle. The statistics registers themselves form the
// result register, so the update path (a 32-bit subtract and compare for
// the round trip, an add and compare for the poll deadline) sets the clock.
module frame_link_statistics
    import flstat_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    flstat_in_if.sink             i_in,
    flstat_out_if.source          o_out
);

    logic   r_ack_en, r_rpt_en, r_poll_en;
    t_stat  r_tout_ticks;

    t_stat  r_tick_now, r_send_tick;
    t_count r_recv_cnt, r_send_cnt, r_crc_cnt, r_cmd_cnt, r_tout_cnt;
    t_seq   r_lost;
    t_stat  r_rtt_sum, r_rtt_max, r_rtt_min;
    logic   r_out_valid, r_status;

    t_stat  n_tick_now, n_send_tick;
    t_count n_recv_cnt, n_send_cnt, n_crc_cnt, n_cmd_cnt, n_tout_cnt;
    t_seq   n_lost;
    t_stat  n_rtt_sum, n_rtt_max, n_rtt_min;
    logic   n_status;

    logic   in_fire;
    t_stat  rtt;
    t_stat  tick_inc;
    t_seq   recv_low;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign rtt        = r_tick_now - r_send_tick;
    assign tick_inc   = r_tick_now + STAT_WIDTH'(1);
    assign recv_low   = r_recv_cnt[SEQ_WIDTH-1:0];

    always_comb begin
        n_tick_now  = r_tick_now;
        n_send_tick = r_send_tick;
        n_recv_cnt  = r_recv_cnt;
        n_send_cnt  = r_send_cnt;
        n_crc_cnt   = r_crc_cnt;
        n_cmd_cnt   = r_cmd_cnt;
        n_tout_cnt  = r_tout_cnt;
        n_lost      = r_lost;
        n_rtt_sum   = r_rtt_sum;
        n_rtt_max   = r_rtt_max;
        n_rtt_min   = r_rtt_min;
        n_status    = 1'b0;
        unique case (i_in.func)
            FUNC_RECV: begin
                n_recv_cnt = r_recv_cnt + COUNT_WIDTH'(1);
                if (r_ack_en) begin
                    n_rtt_sum = r_rtt_sum + rtt;
                    if (rtt > r_rtt_max) n_rtt_max = rtt;
                    if (rtt < r_rtt_min) n_rtt_min = rtt;
                end
            end
            FUNC_CRC: begin
                if (i_in.value == '0) n_crc_cnt = r_crc_cnt + COUNT_WIDTH'(1);
            end
            FUNC_CMD: begin
                if (i_in.value == '0) n_cmd_cnt = r_cmd_cnt + COUNT_WIDTH'(1);
            end
            FUNC_SEQ: begin
                if (i_in.value != recv_low) n_lost = i_in.value - recv_low;
            end
            FUNC_TOUT_RPT: begin
                if (r_rpt_en && i_in.value == '0) n_tout_cnt = r_tout_cnt + COUNT_WIDTH'(1);
            end
            FUNC_SENT: begin
                n_send_cnt = r_send_cnt + COUNT_WIDTH'(1);
                if (r_ack_en) n_send_tick = r_tick_now;
            end
            FUNC_TICK: begin
                n_tick_now = tick_inc;
                // deadline wraps modulo 2^32 and compares unsigned
                if (r_poll_en && tick_inc >= t_stat'(r_send_tick + r_tout_ticks)) begin
                    n_tout_cnt  = r_tout_cnt + COUNT_WIDTH'(1);
                    n_send_tick = tick_inc;
                end
            end
            FUNC_INVALID: begin
                n_status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_en     <= 1'b0;
            r_rpt_en     <= 1'b1;
            r_poll_en    <= 1'b0;
            r_tout_ticks <= TOUT_TICKS_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ACK_TIMING:  r_ack_en     <= i_cfg_data[0];
                CFG_TOUT_REPORT: r_rpt_en     <= i_cfg_data[0];
                CFG_TOUT_POLL:   r_poll_en    <= i_cfg_data[0];
                CFG_TOUT_TICKS:  r_tout_ticks <= i_cfg_data[STAT_WIDTH-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_now  <= '0;
            r_send_tick <= '0;
            r_recv_cnt  <= '0;
            r_send_cnt  <= '0;
            r_crc_cnt   <= '0;
            r_cmd_cnt   <= '0;
            r_tout_cnt  <= '0;
            r_lost      <= '0;
            r_rtt_sum   <= '0;
            r_rtt_max   <= '0;
            r_rtt_min   <= '1;
            r_status    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_tick_now  <= n_tick_now;
                r_send_tick <= n_send_tick;
                r_recv_cnt  <= n_recv_cnt;
                r_send_cnt  <= n_send_cnt;
                r_crc_cnt   <= n_crc_cnt;
                r_cmd_cnt   <= n_cmd_cnt;
                r_tout_cnt  <= n_tout_cnt;
                r_lost      <= n_lost;
                r_rtt_sum   <= n_rtt_sum;
                r_rtt_max   <= n_rtt_max;
                r_rtt_min   <= n_rtt_min;
                r_status    <= n_status;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // state only moves on accept, so it doubles as the held result beat
    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.frames_received = STAT_WIDTH'(r_recv_cnt);
    assign o_out.frames_sent     = STAT_WIDTH'(r_send_cnt);
    assign o_out.crc_errors      = STAT_WIDTH'(r_crc_cnt);
    assign o_out.command_errors  = STAT_WIDTH'(r_cmd_cnt);
    assign o_out.frames_lost     = r_lost;
    assign o_out.timeouts        = STAT_WIDTH'(r_tout_cnt);
    assign o_out.latency_total   = r_rtt_sum;
    assign o_out.latency_max     = r_rtt_max;
    assign o_out.latency_min     = r_rtt_min;

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted beat produced no result");

    a_sent_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.func == FUNC_SENT |=>
            r_send_cnt == t_count'($past(r_send_cnt) + COUNT_WIDTH'(1)))
        else $error("frame sent beat did not bump the send counter");

    a_invalid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.func == FUNC_INVALID |=>
            r_status && $stable(r_recv_cnt) && $stable(r_tout_cnt) && $stable(r_tick_now))
        else $error("invalid beat changed statistics");

    a_min_not_above_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rtt_sum != $past(r_rtt_sum) |-> r_rtt_min <= r_rtt_max)
        else $error("round-trip minimum above maximum");

endmodule

/* dv/frame_link_statistics_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for frame_link_statistics: directed table, then random event traffic.
// Depends on flstat_pkg, flstat_if.sv and the frame_link_statistics RTL.
module frame_link_statistics_tb;
    import flstat_pkg::*;

    typedef struct packed {
        logic  status;
        t_stat frames_received;
        t_stat frames_sent;
        t_stat crc_errors;
        t_stat command_errors;
        t_seq  frames_lost;
        t_stat timeouts;
        t_stat latency_total;
        t_stat latency_max;
        t_stat latency_min;
    } t_stats;

    typedef struct {
        bit       is_write;
        t_cfg_idx reg_idx;
        t_func    func;
        t_stat    data;
        bit       typed;
        t_stats   want;
    } t_step_row;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    flstat_in_if  in_ch ();
    flstat_out_if out_ch ();

    frame_link_statistics u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    // Predictor state and its copy of the registers.
    bit     cfg_ack_timing, cfg_report_en, cfg_poll_en;
    t_stat  cfg_timeout_ticks;
    t_stat  ticks_now, last_send_tick;
    t_count rx_cnt, tx_cnt, crc_cnt, cmd_cnt, tout_cnt;
    t_seq   seq_gap;
    t_stat  rtt_total, rtt_peak, rtt_floor;

    t_stats    pending_stats [$];
    t_step_row steps [$];

    int mismatch_count = 0;
    int beats_checked  = 0;
    int items_sent     = 0;
    int burst_left     = 0;
    int hold_request   = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic t_stats stats_of(int st, int rx, int tx, int crc, int cmd,
                                         int lost, int tout, int tot, int mx, int mn);
        return {1'(st), t_stat'(rx), t_stat'(tx), t_stat'(crc), t_stat'(cmd), t_seq'(lost),
                t_stat'(tout), t_stat'(tot), t_stat'(mx), t_stat'(mn)};
    endfunction

    task automatic reset_predictor();
        cfg_ack_timing    = 1'b0;
        cfg_report_en     = 1'b1;
        cfg_poll_en       = 1'b0;
        cfg_timeout_ticks = TOUT_TICKS_RESET;
        ticks_now         = '0;
        last_send_tick    = '0;
        rx_cnt            = '0;
        tx_cnt            = '0;
        crc_cnt           = '0;
        cmd_cnt           = '0;
        tout_cnt          = '0;
        seq_gap           = '0;
        rtt_total         = '0;
        rtt_peak          = '0;
        rtt_floor         = '1;
    endtask

    // Updates the statistics for one accepted event and returns the beat it should produce.
    function automatic t_stats link_stats_after(t_func f, t_seq v);
        t_stat rtt;
        t_stat deadline;
        logic  st;
        st = 1'b0;
        case (f)
            FUNC_RECV: begin
                rx_cnt = rx_cnt + COUNT_WIDTH'(1);
                if (cfg_ack_timing) begin
                    rtt       = ticks_now - last_send_tick;
                    rtt_total = rtt_total + rtt;
                    if (rtt > rtt_peak) rtt_peak = rtt;
                    if (rtt < rtt_floor) rtt_floor = rtt;
                end
            end
            FUNC_CRC: if (v == '0) crc_cnt = crc_cnt + COUNT_WIDTH'(1);
            FUNC_CMD: if (v == '0) cmd_cnt = cmd_cnt + COUNT_WIDTH'(1);
            FUNC_SEQ: if (v != rx_cnt[15:0]) seq_gap = v - rx_cnt[15:0];
            FUNC_TOUT_RPT: if (cfg_report_en && v == '0) tout_cnt = tout_cnt + COUNT_WIDTH'(1);
            FUNC_SENT: begin
                tx_cnt = tx_cnt + COUNT_WIDTH'(1);
                if (cfg_ack_timing) last_send_tick = ticks_now;
            end
            FUNC_TICK: begin
                ticks_now = ticks_now + STAT_WIDTH'(1);
                if (cfg_poll_en) begin
                    // deadline wraps mod 2^32, so a wrapped one fires at once
                    deadline = last_send_tick + cfg_timeout_ticks;
                    if (ticks_now >= deadline) begin
                        tout_cnt       = tout_cnt + COUNT_WIDTH'(1);
                        last_send_tick = ticks_now;
                    end
                end
            end
            default: st = 1'b1;
        endcase
        return {st, t_stat'(rx_cnt), t_stat'(tx_cnt), t_stat'(crc_cnt), t_stat'(cmd_cnt),
                seq_gap, t_stat'(tout_cnt), rtt_total, rtt_peak, rtt_floor};
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH beat %0d: %s", beats_checked, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic check_stats(t_stats got, t_stats want);
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("frames_received", got.frames_received, want.frames_received);
        check_field("frames_sent", got.frames_sent, want.frames_sent);
        check_field("crc_errors", got.crc_errors, want.crc_errors);
        check_field("command_errors", got.command_errors, want.command_errors);
        check_field("frames_lost", 32'(got.frames_lost), 32'(want.frames_lost));
        check_field("timeouts", got.timeouts, want.timeouts);
        check_field("latency_total", got.latency_total, want.latency_total);
        check_field("latency_max", got.latency_max, want.latency_max);
        check_field("latency_min", got.latency_min, want.latency_min);
    endtask

    // Register mirror and result checking, both at the rising edge.
    always @(posedge clk) begin
        t_stats got;
        if (rst_n) begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ACK_TIMING:  cfg_ack_timing    = cfg_data[0];
                    CFG_TOUT_REPORT: cfg_report_en     = cfg_data[0];
                    CFG_TOUT_POLL:   cfg_poll_en       = cfg_data[0];
                    CFG_TOUT_TICKS:  cfg_timeout_ticks = cfg_data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.status, out_ch.frames_received, out_ch.frames_sent,
                       out_ch.crc_errors, out_ch.command_errors, out_ch.frames_lost,
                       out_ch.timeouts, out_ch.latency_total, out_ch.latency_max,
                       out_ch.latency_min};
                if (pending_stats.size() == 0)
                    report_mismatch("result beat with nothing pending");
                else
                    check_stats(got, pending_stats.pop_front());
                beats_checked++;
            end
        end
    end

    // Receiver: random ready patterns, all-ready stretches, and long hold-offs on request.
    initial begin
        int         hold_left;
        int         mode_left;
        int         pos;
        logic [7:0] pattern;
        hold_left    = 0;
        mode_left    = 0;
        pos          = 0;
        pattern      = '1;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(16, 80);
                    pattern   = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
                    if (pattern == '0) pattern = 8'h01;
                end
                mode_left--;
                out_ch.ready <= pattern[pos];
                pos = (pos + 1) % 8;
            end
        end
    end

    // Present one event beat, in bursts with random gaps, and predict it on acceptance.
    task automatic send_event(t_func f, t_seq v, bit typed = 1'b0, t_stats want = '0);
        int     gap;
        t_stats predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.func  <= f;
        in_ch.value <= v;
        do @(posedge clk); while (!in_ch.ready);
        predicted = link_stats_after(f, v);
        pending_stats.push_back(typed ? want : predicted);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_stat data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic t_seq check_flag();
        return ($urandom_range(0, 3) == 0) ? t_seq'(0) : t_seq'($urandom_range(1, 65535));
    endfunction

    task automatic add_item(t_func f, t_seq v, int typed = 0, t_stats want = '0);
        t_step_row row;
        row.is_write = 1'b0;
        row.reg_idx  = CFG_ACK_TIMING;
        row.func     = f;
        row.data     = t_stat'(v);
        row.typed    = (typed != 0);
        row.want     = want;
        steps.push_back(row);
    endtask

    task automatic add_write(t_cfg_idx idx, t_stat data);
        t_step_row row;
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.func     = FUNC_TICK;
        row.data     = data;
        row.typed    = 1'b0;
        row.want     = '0;
        steps.push_back(row);
    endtask

    task automatic build_directed();
        // reset registers: no timing, reports on, no poll
        add_item(FUNC_INVALID, 16'hFFFF, 1, stats_of(1, 0, 0, 0, 0, 0, 0, 0, 0, '1));
        add_item(FUNC_RECV, 16'h0000, 1, stats_of(0, 1, 0, 0, 0, 0, 0, 0, 0, '1));
        add_item(FUNC_CRC, 16'h0000, 1, stats_of(0, 1, 0, 1, 0, 0, 0, 0, 0, '1));
        add_item(FUNC_CRC, 16'hFFFF);
        add_item(FUNC_CMD, 16'h0000, 1, stats_of(0, 1, 0, 1, 1, 0, 0, 0, 0, '1));
        add_item(FUNC_CMD, 16'h0001);
        add_item(FUNC_SEQ, 16'h0001, 1, stats_of(0, 1, 0, 1, 1, 0, 0, 0, 0, '1));
        add_item(FUNC_SEQ, 16'h0000, 1, stats_of(0, 1, 0, 1, 1, 'hFFFF, 0, 0, 0, '1));
        add_item(FUNC_SEQ, 16'h8000);
        add_item(FUNC_TOUT_RPT, 16'h0000, 1, stats_of(0, 1, 0, 1, 1, 'h7FFF, 1, 0, 0, '1));
        add_item(FUNC_TOUT_RPT, 16'hFFFF);
        add_item(FUNC_SENT, 16'hFFFF, 1, stats_of(0, 1, 1, 1, 1, 'h7FFF, 1, 0, 0, '1));
        add_item(FUNC_TICK, 16'h0000);
        add_item(FUNC_INVALID, 16'h0000, 1, stats_of(1, 1, 1, 1, 1, 'h7FFF, 1, 0, 0, '1));
        // round trip and poll deadline
        add_write(CFG_ACK_TIMING, 1);
        add_write(CFG_TOUT_POLL, 1);
        add_write(CFG_TOUT_TICKS, 3);
        add_item(FUNC_SENT, 16'h0000);
        add_item(FUNC_TICK, 16'h0000);
        add_item(FUNC_TICK, 16'h0000);
        add_item(FUNC_RECV, 16'h0000);
        add_item(FUNC_TICK, 16'h0000);
        add_item(FUNC_RECV, 16'h0000);
        // wrapped deadline fires at once
        add_write(CFG_TOUT_TICKS, 32'hFFFF_FFFF);
        add_item(FUNC_TICK, 16'h0000);
        add_write(CFG_TOUT_REPORT, 0);
        add_item(FUNC_TOUT_RPT, 16'h0000);
    endtask

    // Mostly send/tick/receive exchanges with random content, plus loose single events.
    task automatic run_random(int count);
        int    stop_at;
        int    n_ticks;
        t_func f;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 6) begin
                send_event(FUNC_SENT, t_seq'($urandom));
                n_ticks = $urandom_range(0, 6);
                repeat (n_ticks) send_event(FUNC_TICK, t_seq'($urandom));
                if ($urandom_range(0, 4) == 0)
                    send_event(FUNC_TOUT_RPT, check_flag());
                else
                    send_event(FUNC_RECV, t_seq'($urandom));
                if ($urandom_range(0, 3) != 0)
                    send_event(FUNC_SEQ, rx_cnt[15:0]);
                else
                    send_event(FUNC_SEQ, t_seq'($urandom));
                send_event(FUNC_CRC, check_flag());
                send_event(FUNC_CMD, check_flag());
            end else begin
                f = t_func'($urandom_range(0, 7));
                send_event(f, ($urandom_range(0, 1) == 0) ? check_flag() : t_seq'($urandom));
            end
        end
    endtask

    initial begin
        t_stat phase_cfg [6][4];
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_ACK_TIMING;
        cfg_data    = '0;
        in_ch.valid = 1'b0;
        in_ch.func  = FUNC_TICK;
        in_ch.value = '0;
        reset_predictor();
        phase_cfg = '{'{1, 1, 1, 5}, '{1, 0, 1, 0}, '{0, 1, 1, 32'hFFFF_FFFF},
                      '{1, 1, 0, 1000}, '{0, 0, 0, 0}, '{1, 1, 1, 2}};
        phase_cfg[5] = '{$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 8)};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        build_directed();
        foreach (steps[i]) begin
            if (steps[i].is_write) begin
                wait_idle();
                write_reg(steps[i].reg_idx, steps[i].data);
            end else begin
                send_event(steps[i].func, t_seq'(steps[i].data), steps[i].typed, steps[i].want);
            end
        end

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            for (int r = 0; r < 4; r++) write_reg(t_cfg_idx'(r), phase_cfg[p][r]);
            if (p == 2) begin
                run_random(20);
                // long receiver hold-off while events keep coming
                hold_request = 60;
            end
            run_random((p == 2) ? 85 : 105);
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
